### design/opsbf_pkg.sv
// Shared types, constants and arithmetic helpers for the one-pole shelf
// boost filter. No dependencies; every other design file imports this one.
package opsbf_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;

  localparam int CH_IN_W    = 3;
  localparam int CH_IN_NUM  = 1 << CH_IN_W;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ALIGN      = 49 - SAMPLE_BITS;
  localparam int FRAC_BITS  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [24:0] INPUT_SCALE_RST = 25'd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_MODE     = 3'd1,
    REG_FEEDBACK = 3'd2,
    REG_SCALE    = 3'd3,
    REG_WARP     = 3'd4,
    REG_BOOST    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               enable;
    logic               filter_mode;
    logic signed [31:0] feedback_coeff;
    logic [24:0]        input_scale;
    logic [30:0]        warp_gain;
    logic signed [31:0] boost_gain;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_FB = 2'd0,
    MUL_SC = 2'd1,
    MUL_WG = 2'd2,
    MUL_BG = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     pass;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_d;
    logic     ld_x;
    logic     ld_sum;
    logic     ld_t;
    logic     ld_res;
  } dp_cmd_t;

  // Channel numbers wrap modulo the channel count.
  typedef logic [CH_W-1:0] ch_map_t [CH_IN_NUM];

  function automatic ch_map_t ch_map_init();
    ch_map_t m;
    for (int i = 0; i < CH_IN_NUM; i++) begin
      m[i] = CH_W'(i % CHANNELS);
    end
    return m;
  endfunction

  localparam ch_map_t CH_MAP = ch_map_init();

  // Round half up, then arithmetic shift right.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic signed [63:0] u;
    u = v + (64'sd1 <<< (n - 1));
    return u >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sb(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

### design/opsbf_if.sv
// Request channels of the filter: sample input and filtered output.
// Depends on opsbf_pkg for the sample width.
interface opsbf_in_if;
  import opsbf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [CH_IN_W-1:0]            channel;
  modport source (output valid, sample_in, channel, input ready);
  modport sink   (input valid, sample_in, channel, output ready);
endinterface

interface opsbf_out_if;
  import opsbf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

### design/opsbf_cfg.sv
// Configuration register file: enable, mode and the four coefficients.
// Depends on opsbf_pkg for the register indexes and cfg_t.
module opsbf_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [opsbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [opsbf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output opsbf_pkg::cfg_t                      cfg
);
  import opsbf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:   cfg_nxt.enable         = cfg_wdata[0];
        REG_MODE:     cfg_nxt.filter_mode    = cfg_wdata[0];
        REG_FEEDBACK: cfg_nxt.feedback_coeff = cfg_wdata[31:0];
        REG_SCALE:    cfg_nxt.input_scale    = cfg_wdata[24:0];
        REG_WARP:     cfg_nxt.warp_gain      = cfg_wdata[30:0];
        REG_BOOST:    cfg_nxt.boost_gain     = cfg_wdata[31:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.filter_mode    <= 1'b0;
      cfg_r.feedback_coeff <= '0;
      cfg_r.input_scale    <= INPUT_SCALE_RST;
      cfg_r.warp_gain      <= '0;
      cfg_r.boost_gain     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/opsbf_ctrl.sv
// Sequencer for one filter step: steps the shared multiplier through the
// feedback, scale, low-pass warp and boost products; owns output valid.
// Depends on opsbf_pkg for dp_cmd_t and mul_sel_t.
module opsbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_enable,
  input  logic               cfg_mode,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output opsbf_pkg::dp_cmd_t cmd
);
  import opsbf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MFB  = 10'b0000000010,
    S_D    = 10'b0000000100,
    S_MSC  = 10'b0000001000,
    S_X    = 10'b0000010000,
    S_SUM  = 10'b0000100000,
    S_MWG  = 10'b0001000000,
    S_T    = 10'b0010000000,
    S_MBG  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.pass      = pass_r;
    cmd.mul_sel   = MUL_FB;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          pass_nxt    = ~cfg_enable;
          state_nxt   = cfg_enable ? S_MFB : S_DONE;
        end
      end
      S_MFB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FB;
        state_nxt   = S_D;
      end
      S_D: begin
        cmd.ld_d  = 1'b1;
        state_nxt = S_MSC;
      end
      S_MSC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SC;
        state_nxt   = S_X;
      end
      S_X: begin
        cmd.ld_x  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // high-pass skips the warp product
        cmd.ld_sum = 1'b1;
        state_nxt  = cfg_mode ? S_MBG : S_MWG;
      end
      S_MWG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WG;
        state_nxt   = S_T;
      end
      S_T: begin
        cmd.ld_t  = 1'b1;
        state_nxt = S_MBG;
      end
      S_MBG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BG;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.ld_res    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_pass_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !cfg_enable) |=> (state_r == S_DONE))
    else $error("pass-through request did not go straight to result");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("output valid rose outside the result step");

  a_hp_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && cfg_mode) |=> (state_r == S_MBG))
    else $error("high-pass step did not skip the warp product");

endmodule

### design/opsbf_dp.sv
// Datapath: channel state memory, shared 33x32 multiplier with product
// register, rounding and saturation, and the output sample register.
// Depends on opsbf_pkg for cfg_t, dp_cmd_t and the arithmetic helpers.
module opsbf_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  opsbf_pkg::cfg_t                         cfg,
  input  opsbf_pkg::dp_cmd_t                      cmd,
  input  logic signed [opsbf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic [opsbf_pkg::CH_IN_W-1:0]           channel,
  output logic signed [opsbf_pkg::SAMPLE_BITS-1:0] sample_out
);
  import opsbf_pkg::*;

  logic [31:0]                   mem_r [CHANNELS];
  logic [CHANNELS-1:0]           vld_r;
  logic [CH_W-1:0]               ch_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic signed [31:0]            y_r;
  logic signed [31:0]            x_r;
  logic signed [32:0]            t_r;
  logic signed [63:0]            prod_r;
  logic signed [SAMPLE_BITS-1:0] res_r;

  logic [CH_W-1:0]    ch_in;
  logic signed [32:0] a_op;
  logic signed [31:0] b_op;
  logic signed [64:0] prod_full;
  logic signed [63:0] d_val;
  logic signed [31:0] x_nxt;
  logic signed [32:0] diff;
  logic signed [31:0] diff_sat;

  assign ch_in = CH_MAP[channel];

  always_comb begin
    a_op = (cmd.mul_sel == MUL_FB) ? {y_r[31], y_r} : t_r;
    case (cmd.mul_sel)
      MUL_FB:  b_op = cfg.feedback_coeff;
      MUL_SC:  b_op = {7'd0, cfg.input_scale};
      MUL_WG:  b_op = {1'b0, cfg.warp_gain};
      default: b_op = cfg.boost_gain;
    endcase
  end

  assign prod_full = a_op * b_op;

  assign d_val    = ({{(64-SAMPLE_BITS){s_r[SAMPLE_BITS-1]}}, s_r} <<< ALIGN) - prod_r;
  assign x_nxt    = sat32(rnd_shr(prod_r, FRAC_BITS));
  assign diff     = {x_r[31], x_r} - {y_r[31], y_r};
  assign diff_sat = sat32({{31{diff[32]}}, diff});

  // state memory: valid bits make unwritten channels read as zero
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y_r <= vld_r[ch_in] ? mem_r[ch_in] : 32'sd0;
    end
    if (cmd.ld_x) begin
      mem_r[ch_r] <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.ld_x) begin
      vld_r[ch_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_r  <= sample_in;
      ch_r <= ch_in;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_full[63:0];
    end
    if (cmd.ld_d) begin
      t_r <= 33'(sat32(rnd_shr(d_val, FRAC_BITS)));
    end
    if (cmd.ld_x) begin
      x_r <= x_nxt;
    end
    if (cmd.ld_sum) begin
      t_r <= cfg.filter_mode ? 33'(diff_sat) : ({x_r[31], x_r} + {y_r[31], y_r});
    end
    if (cmd.ld_t) begin
      t_r <= 33'(sat32(rnd_shr(prod_r, FRAC_BITS)));
    end
    if (cmd.ld_res) begin
      res_r <= cmd.pass ? s_r : sat_sb(rnd_shr(prod_r, ALIGN));
    end
  end

  assign sample_out = res_r;

endmodule

### design/one_pole_shelf_boost_filter_unit.sv
// One-pole shelf boost filter, multichannel, one shared multiplier.
// A request passes through the multiplier four times in low-pass mode, three
// in high-pass mode and not at all with enable clear; no new request is taken
// until the current result has entered the output register.
// Synchronous active-low reset clears config to defaults and all channel
// state to zero at once through per-channel valid bits.
module one_pole_shelf_boost_filter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  opsbf_in_if.sink                         in_if,
  opsbf_out_if.source                      out_if,
  input  logic                             cfg_we,
  input  logic [opsbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opsbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import opsbf_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  opsbf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  opsbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_enable (cfg.enable),
    .cfg_mode   (cfg.filter_mode),
    .in_valid   (in_if.valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_if.ready),
    .cmd        (cmd)
  );

  opsbf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sample_in  (in_if.sample_in),
    .channel    (in_if.channel),
    .sample_out (out_if.sample_out)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule

### tb/tb_one_pole_shelf_boost_filter_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the one-pole shelf boost filter: drives sample requests,
// predicts every filtered sample in fixed point and compares it with the block.
// Depends on opsbf_pkg, the opsbf_in_if / opsbf_out_if interfaces and the top level.
module tb_one_pole_shelf_boost_filter_unit;
  import opsbf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CH_IN_W-1:0]            chan_t;

  localparam int      DRAIN_CYCLES = 24;
  localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  opsbf_in_if  in_ch ();
  opsbf_out_if out_ch ();

  one_pole_shelf_boost_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the coefficient registers and the per-channel filter state.
  bit     cfg_enable;
  bit     cfg_mode;
  int     cfg_feedback;
  longint cfg_scale;
  longint cfg_warp;
  int     cfg_boost;
  int     chan_state [CHANNELS];

  sample_t expected_samples[$];

  int send_idle_pct = 35;
  int recv_idle_pct = 81;
  int hold_off_left = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_fail        = 0;
  int n_writes      = 0;
  int n_pass        = 0;
  int n_low         = 0;
  int n_high        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Round half up by `shift` bits, then clamp to a signed `bits`-wide range.
  function automatic longint round_sat(input longint v, input int shift, input int bits);
    longint lim;
    if (shift > 0) v = (v + (longint'(1) <<< (shift - 1))) >>> shift;
    lim = (longint'(1) <<< (bits - 1)) - 1;
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic sample_t filter_predict(input sample_t smp, input chan_t ch);
    int     idx;
    longint y;
    longint d;
    longint x;
    longint t;
    if (!cfg_enable) begin
      n_pass++;
      return smp;
    end
    idx = int'(ch) % CHANNELS;
    y   = chan_state[idx];
    d   = round_sat(longint'(smp) * (longint'(1) <<< ALIGN) - y * longint'(cfg_feedback),
                    FRAC_BITS, 32);
    x   = round_sat(d * cfg_scale, FRAC_BITS, 32);
    chan_state[idx] = int'(x);
    if (cfg_mode) begin
      n_high++;
      t = round_sat(x - y, 0, 32);
    end else begin
      n_low++;
      t = round_sat((x + y) * cfg_warp, FRAC_BITS, 32);
    end
    return sample_t'(round_sat(t * longint'(cfg_boost), ALIGN, SAMPLE_BITS));
  endfunction

  task automatic send_request(input sample_t smp, input chan_t ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = smp;
    in_ch.channel   = ch;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    expected_samples.push_back(filter_predict(smp, ch));
    n_sent++;
  endtask

  // Drop valid, wait out every pending result, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:   cfg_enable   = val[0];
      REG_MODE:     cfg_mode     = val[0];
      REG_FEEDBACK: cfg_feedback = int'(val);
      REG_SCALE:    cfg_scale    = longint'(val[24:0]);
      REG_WARP:     cfg_warp     = longint'(val[30:0]);
      REG_BOOST:    cfg_boost    = int'(val);
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_coeffs(input logic [31:0] fb, input logic [31:0] sc,
                              input logic [31:0] wg, input logic [31:0] bg);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_SCALE, sc);
    write_reg(REG_WARP, wg);
    write_reg(REG_BOOST, bg);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly a consistent coefficient set (w, 1/(1+w), w-1), else extremes or raw bits.
  task automatic load_random_setting();
    logic [31:0] fb_pick [3] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
    logic [31:0] sc_pick [3] = '{32'h0000_0000, 32'h0100_0000, 32'h01ff_ffff};
    logic [31:0] wg_pick [3] = '{32'h0000_0000, 32'h7fff_ffff, 32'h0100_0000};
    logic [31:0] bg_pick [3] = '{32'h8000_0000, 32'h7fff_ffff, 32'hff00_0000};
    logic [31:0] w;
    int          kind;
    kind = $urandom_range(9);
    write_reg(REG_ENABLE, ($urandom_range(7) != 0) ? 32'd1 : 32'd0);
    write_reg(REG_MODE, 32'($urandom_range(1)));
    if (kind < 6) begin
      w = $urandom_range(32'd262144, 32'd100663296);
      write_coeffs(w - 32'd16777216, 32'((64'd1 << 48) / (64'd16777216 + w)), w,
                   $urandom_range(0, 32'd268435456) - 32'd16777216);
    end else if (kind < 8) begin
      write_coeffs(fb_pick[$urandom_range(2)], sc_pick[$urandom_range(2)],
                   wg_pick[$urandom_range(2)], bg_pick[$urandom_range(2)]);
    end else begin
      write_coeffs($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_pass_through();
    send_request(SAMPLE_MAX, 3'd0);
    send_request(SAMPLE_MIN, 3'd7);
    send_request('0, 3'd3);
    send_request(-sample_t'(1), 3'd5);
  endtask

  task automatic test_low_pass();
    settle();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_MODE, 32'd0);
    // w = 0.25: feedback -0.75, scale 0.8, unity boost
    write_coeffs(-32'sd12582912, 32'd13421773, 32'd4194304, 32'd16777216);
    send_request(SAMPLE_MAX, 3'd0);
    send_request(SAMPLE_MAX, 3'd0);
    send_request(SAMPLE_MIN, 3'd0);
    send_request('0, 3'd1);
    send_request(SAMPLE_MIN, 3'd7);
    send_request(SAMPLE_MAX, 3'd7);
  endtask

  task automatic test_high_pass();
    settle();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_BOOST, 32'd50331648);
    send_request(SAMPLE_MAX, 3'd2);
    send_request(SAMPLE_MAX, 3'd2);
    send_request(SAMPLE_MAX, 3'd2);
    send_request(SAMPLE_MIN, 3'd2);
    send_request(-sample_t'(1), 3'd6);
  endtask

  // Coefficients at the edges of their widths: scale above 1.0, boost below -1.0.
  task automatic test_coeff_extremes();
    settle();
    write_reg(REG_MODE, 32'd0);
    write_coeffs(32'h8000_0000, 32'h01ff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_request(SAMPLE_MAX, 3'd4);
    send_request(SAMPLE_MIN, 3'd4);
    send_request(SAMPLE_MAX, 3'd4);
    settle();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_BOOST, 32'h7fff_ffff);
    send_request(SAMPLE_MIN, 3'd4);
    send_request(SAMPLE_MAX, 3'd1);
    send_request(SAMPLE_MIN, 3'd1);
  endtask

  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int    left;
    int    burst;
    chan_t ch;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    left = n_items;
    ch   = '0;
    while (left > 0) begin
      settle();
      load_random_setting();
      burst = $urandom_range(25, 60);
      if (burst > left) burst = left;
      repeat (burst) begin
        // stay on one channel half the time so the state recursion builds up
        if ($urandom_range(1)) ch = chan_t'($urandom);
        send_request(random_sample(), ch);
      end
      left -= burst;
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_output_backpressure(input int n_items);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 400;
    repeat (n_items) send_request(random_sample(), chan_t'($urandom));
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sample_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_checked++;
      if (expected_samples.size() == 0) begin
        $error("sample_out: result with no request pending, actual %0d", out_ch.sample_out);
        n_fail++;
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample_out !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, out_ch.sample_out);
          n_fail++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.channel   = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_ENABLE;
    cfg_wdata       = '0;
    cfg_enable      = 1'b0;
    cfg_mode        = 1'b0;
    cfg_feedback    = 0;
    cfg_scale       = 16777216;
    cfg_warp        = 0;
    cfg_boost       = 0;
    foreach (chan_state[i]) chan_state[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pass_through();
    test_low_pass();
    test_high_pass();
    test_coeff_extremes();
    test_random_traffic(300, 35, 81);
    test_random_traffic(300, 81, 35);
    test_output_backpressure(30);
    test_random_traffic(220, 0, 0);
    settle();

    if (expected_samples.size() != 0) begin
      $error("sample_out: %0d results never arrived", expected_samples.size());
      n_fail++;
    end
    $display("Sent %0d requests over %0d register writes, checked %0d results.",
             n_sent, n_writes, n_checked);
    $display("Paths taken: %0d pass-through, %0d low-pass, %0d high-pass.",
             n_pass, n_low, n_high);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/opsbf_pkg.sv
design/opsbf_if.sv
design/opsbf_cfg.sv
design/opsbf_ctrl.sv
design/opsbf_dp.sv
design/one_pole_shelf_boost_filter_unit.sv
tb/tb_one_pole_shelf_boost_filter_unit.sv
